// File: rtl/core/aspg_pkg.sv
// ----------------------------------------------------------------------------
// aspg_pkg
// Shared types and constants of the armed step and direction pulse generator.
// ----------------------------------------------------------------------------
package aspg_pkg;

  localparam int unsigned AXES_DEF = 3;
  localparam int unsigned TICK_RATE_DEF = 1000000;
  localparam int unsigned FIRST_DELAY_DEF = 20;

  localparam int unsigned AGE_W = 17;
  localparam int unsigned TOG_W = 25;
  localparam int unsigned HP_W = 19;
  localparam int unsigned CFG_W = 24;
  localparam int unsigned RATE_W = 20;
  localparam int unsigned STEP_W = 24;
  localparam int unsigned QUO_W = 27;

  localparam logic [AGE_W-1:0] AGE_MAX = '1;
  localparam logic [HP_W-1:0] HALF_MAX = '1;

  typedef enum logic [2:0] {
    CMD_TICK = 3'd0,
    CMD_ARM = 3'd1,
    CMD_HEARTBEAT = 3'd2,
    CMD_DISARM = 3'd3,
    CMD_MOVE = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_NOT_ARMED = 3'd1,
    ST_WATCHDOG = 3'd2,
    ST_ARGUMENT = 3'd3,
    ST_BUSY = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    REG_WD_LIMIT = 2'd0,
    REG_MAX_STEPS = 2'd1,
    REG_MIN_RATE = 2'd2,
    REG_MAX_RATE = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV = 4'b0010,
    S_AXIS = 4'b0100,
    S_OUT = 4'b1000
  } state_t;

endpackage

// File: rtl/core/armed_stepper_pulse_generator_top.sv
// ----------------------------------------------------------------------------
// armed_stepper_pulse_generator_top
// A good arm or heartbeat, a rejected move and an undefined command go from
// accept straight to S_OUT, which raises out_valid. Tick, disarm, a failed arm or
// heartbeat and a move stopped by the watchdog pass through S_AXIS, one axis per
// cycle through one shared countdown unit, then S_OUT. An accepted move first runs
// S_DIV, a restoring division of the tick rate by twice the step rate, then S_AXIS.
// The next transaction is accepted only after the result has been taken and
// out_valid has dropped. Synchronous active-high reset: disarmed,
// axes stopped, registers at defaults.
// ----------------------------------------------------------------------------
module armed_stepper_pulse_generator_top
  import aspg_pkg::*;
#(
  parameter int unsigned AXES = AXES_DEF,
  parameter int unsigned TICK_RATE_HZ = TICK_RATE_DEF,
  parameter int unsigned FIRST_DELAY = FIRST_DELAY_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          cmd,
  input  logic                ms_strobe,
  input  logic                safety_ok,
  input  logic [2:0]          axis_index,
  input  logic [1:0]          direction,
  input  logic [STEP_W-1:0]   step_count,
  input  logic [RATE_W-1:0]   step_rate,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          status,
  output logic                armed,
  output logic                healthy,
  output logic [2:0]          pulse_levels,
  output logic [2:0]          direction_levels,
  output logic [2:0]          moving
);

  localparam int unsigned AX_W = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int unsigned QC_W = $clog2(QUO_W + 1);
  localparam logic [QUO_W-1:0] TICK_Q = QUO_W'(TICK_RATE_HZ);

  logic [15:0]       wd_limit;
  logic [STEP_W-1:0] max_steps;
  logic [HP_W-1:0]   min_rate;
  logic [HP_W-1:0]   max_rate;

  state_t state;
  logic                is_armed, is_healthy;
  logic [AGE_W-1:0]    heartbeat_age;
  logic [TOG_W-1:0]    toggles_left [AXES];
  logic [HP_W-1:0]     half_period [AXES];
  logic [HP_W-1:0]     ticks_to_toggle [AXES];
  logic [AXES-1:0]     pulse_level, direction_level;

  // latched transaction
  logic [2:0]          c_cmd;
  logic [2:0]          c_axis;
  logic                c_dir;
  logic [STEP_W-1:0]   c_steps;
  logic [RATE_W:0]     divisor;
  logic [AX_W-1:0]     ax;
  logic [QC_W-1:0]     qcnt;
  logic [QUO_W-1:0]    quo;
  logic [QUO_W:0]      rem;
  logic [2:0]          st;

  logic [QUO_W:0] rem_sh;
  logic           rem_ge;
  logic           any_busy;
  logic           wd_trip;

  assign rem_sh = {rem[QUO_W-1:0], quo[QUO_W-1]};
  assign rem_ge = rem_sh >= {{(QUO_W-RATE_W){1'b0}}, divisor};
  assign wd_trip = is_armed && (heartbeat_age > {1'b0, wd_limit});

  always_comb begin
    any_busy = 1'b0;
    for (int i = 0; i < AXES; i++) begin
      any_busy = any_busy | (toggles_left[i] != '0);
    end
  end

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wd_limit <= 16'd250;
      max_steps <= '1;
      min_rate <= HP_W'(1);
      max_rate <= HP_W'(20000);
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_WD_LIMIT: wd_limit <= cfg_data[15:0];
        REG_MAX_STEPS: max_steps <= cfg_data[STEP_W-1:0];
        REG_MIN_RATE: min_rate <= cfg_data[HP_W-1:0];
        REG_MAX_RATE: max_rate <= cfg_data[HP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      is_armed <= 1'b0;
      is_healthy <= 1'b0;
      heartbeat_age <= '0;
      pulse_level <= '0;
      direction_level <= '0;
      for (int i = 0; i < AXES; i++) begin
        toggles_left[i] <= '0;
        half_period[i] <= '0;
        ticks_to_toggle[i] <= '0;
      end
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            c_cmd <= cmd;
            c_axis <= axis_index;
            c_dir <= direction[0];
            c_steps <= step_count;
            divisor <= {step_rate, 1'b0};
            quo <= TICK_Q;
            rem <= '0;
            qcnt <= '0;
            ax <= '0;
            st <= ST_OK;
            state <= S_AXIS;
            unique case (cmd)
              CMD_TICK: begin
                if (ms_strobe && heartbeat_age != AGE_MAX)
                  heartbeat_age <= heartbeat_age + 1'b1;
              end
              CMD_ARM: begin
                if (!safety_ok) begin
                  st <= ST_NOT_ARMED;
                  c_cmd <= CMD_DISARM;
                end else begin
                  heartbeat_age <= '0;
                  is_armed <= 1'b1;
                  is_healthy <= 1'b1;
                  state <= S_OUT;
                end
              end
              CMD_HEARTBEAT: begin
                if (!safety_ok || !is_armed) begin
                  st <= ST_NOT_ARMED;
                  c_cmd <= CMD_DISARM;
                end else begin
                  heartbeat_age <= '0;
                  is_healthy <= 1'b1;
                  state <= S_OUT;
                end
              end
              CMD_DISARM: ;
              CMD_MOVE: begin
                // watchdog, then checks in order, then divide
                if (wd_trip || !is_armed) begin
                  st <= ST_NOT_ARMED;
                  if (wd_trip) c_cmd <= CMD_DISARM;
                  else state <= S_OUT;
                end else if (!is_healthy) begin
                  st <= ST_WATCHDOG;
                  state <= S_OUT;
                end else if ({5'd0, axis_index} >= 8'(AXES) || direction > 2'd1 ||
                             step_count == '0 || step_count > max_steps ||
                             step_rate < {1'b0, min_rate} ||
                             step_rate > {1'b0, max_rate}) begin
                  st <= ST_ARGUMENT;
                  state <= S_OUT;
                end else if (any_busy) begin
                  st <= ST_BUSY;
                  state <= S_OUT;
                end else begin
                  state <= S_DIV;
                end
              end
              default: begin
                st <= ST_ARGUMENT;
                state <= S_OUT;
              end
            endcase
          end
        end
        S_DIV: begin
          // restoring division, one quotient bit a cycle
          rem <= rem_ge ? rem_sh - {{(QUO_W-RATE_W){1'b0}}, divisor} : rem_sh;
          quo <= {quo[QUO_W-2:0], rem_ge};
          qcnt <= qcnt + 1'b1;
          if (qcnt == QC_W'(QUO_W - 1)) state <= S_AXIS;
        end
        S_AXIS: begin
          // one axis per cycle
          unique case (c_cmd)
            CMD_TICK: begin
              if (wd_trip) begin
                toggles_left[ax] <= '0;
                ticks_to_toggle[ax] <= '0;
                pulse_level[ax] <= 1'b0;
                direction_level[ax] <= 1'b0;
              end else if (toggles_left[ax] != '0) begin
                if (ticks_to_toggle[ax] > HP_W'(1)) begin
                  ticks_to_toggle[ax] <= ticks_to_toggle[ax] - 1'b1;
                end else if (toggles_left[ax] == TOG_W'(1)) begin
                  toggles_left[ax] <= '0;
                  pulse_level[ax] <= 1'b0;
                  ticks_to_toggle[ax] <= '0;
                end else begin
                  toggles_left[ax] <= toggles_left[ax] - 1'b1;
                  pulse_level[ax] <= ~pulse_level[ax];
                  ticks_to_toggle[ax] <= half_period[ax];
                end
              end
            end
            CMD_DISARM: begin
              toggles_left[ax] <= '0;
              ticks_to_toggle[ax] <= '0;
              pulse_level[ax] <= 1'b0;
              direction_level[ax] <= 1'b0;
            end
            CMD_MOVE: begin
              if ({5'd0, c_axis} == 8'(ax)) begin
                direction_level[ax] <= c_dir;
                toggles_left[ax] <= {c_steps, 1'b0};
                ticks_to_toggle[ax] <= HP_W'(FIRST_DELAY);
                pulse_level[ax] <= 1'b0;
                if (divisor == '0 || quo > QUO_W'(HALF_MAX)) half_period[ax] <= HALF_MAX;
                else if (quo == '0) half_period[ax] <= HP_W'(1);
                else half_period[ax] <= quo[HP_W-1:0];
              end
            end
            default: ;
          endcase
          if (ax == AX_W'(AXES - 1)) begin
            state <= S_OUT;
            if (c_cmd == CMD_DISARM || (c_cmd == CMD_TICK && wd_trip)) begin
              is_armed <= 1'b0;
              is_healthy <= 1'b0;
            end
          end else begin
            ax <= ax + 1'b1;
          end
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    status = st;
    armed = is_armed;
    healthy = is_healthy;
    pulse_levels = '0;
    direction_levels = '0;
    moving = '0;
    for (int i = 0; i < AXES && i < 3; i++) begin
      pulse_levels[i] = pulse_level[i];
      direction_levels[i] = direction_level[i];
      moving[i] = toggles_left[i] != '0;
    end
  end

endmodule
